// File: rtl/rotated_pixel_format_writer_top_defines.svh
// Assertion macros for the rotated pixel format writer
`ifndef ROTATED_PIXEL_FORMAT_WRITER_TOP_DEFINES_SVH
`define ROTATED_PIXEL_FORMAT_WRITER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define RPFW_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rpfw assertion failed");
`define RPFW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rpfw assertion failed");
`else
`define RPFW_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define RPFW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/rpfw_pkg.sv
// Types, constants and register codes shared by the pixel writer files
package rpfw_pkg;

	localparam int unsigned ADDR_W     = 24;
	localparam int unsigned OFF_W      = 31;
	localparam int unsigned POS_W      = 12;
	localparam int unsigned DIM_W      = 13;
	localparam int unsigned STRIDE_W   = 14;
	localparam int unsigned BUF_W      = 25;
	localparam int unsigned PIX_W      = 32;
	localparam int unsigned PBITS_W    = 6;
	localparam int unsigned SBYTES_W   = 3;
	localparam int unsigned CFG_ADDR_W = 4;
	localparam int unsigned CFG_DATA_W = 25;
	localparam int unsigned CRD_W      = 15;

	typedef enum logic [1:0] {
		ROT_0   = 2'd0,
		ROT_90  = 2'd1,
		ROT_180 = 2'd2,
		ROT_270 = 2'd3
	} rot_t;

	localparam logic [PBITS_W-1:0] PB_RGB565   = 6'd16;
	localparam logic [PBITS_W-1:0] PB_RGB666   = 6'd18;
	localparam logic [PBITS_W-1:0] PB_RGB888   = 6'd24;
	localparam logic [PBITS_W-1:0] PB_RGBA8888 = 6'd32;

	localparam logic [SBYTES_W-1:0] SB_MIN = 3'd2;
	localparam logic [SBYTES_W-1:0] SB_MID = 3'd3;
	localparam logic [SBYTES_W-1:0] SB_MAX = 3'd4;

	localparam logic [CFG_ADDR_W-1:0] REG_ROTATION     = 4'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_PIXEL_BITS   = 4'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_STORE_BYTES  = 4'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_RED_FIRST    = 4'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_PANEL_WIDTH  = 4'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_PANEL_HEIGHT = 4'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_LINE_STRIDE  = 4'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_BUFFER_BYTES = 4'd7;

	typedef struct packed {
		rot_t                rotation;
		logic [PBITS_W-1:0]  pixel_bits;
		logic [SBYTES_W-1:0] store_bytes;
		logic                red_first;
		logic [DIM_W-1:0]    panel_width;
		logic [DIM_W-1:0]    panel_height;
		logic [STRIDE_W-1:0] line_stride;
		logic [BUF_W-1:0]    buffer_bytes;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		rotation:     ROT_0,
		pixel_bits:   6'd32,
		store_bytes:  3'd4,
		red_first:    1'b1,
		panel_width:  13'd640,
		panel_height: 13'd480,
		line_stride:  14'd2560,
		buffer_bytes: 25'd1228800
	};

endpackage

// File: rtl/rpfw_ifs.sv
// Handshake interfaces for pixel input, framebuffer write output and config writes
interface rpfw_pixel_if;
	import rpfw_pkg::*;
	logic             valid;
	logic             ready;
	logic [POS_W-1:0] pos_x;
	logic [POS_W-1:0] pos_y;
	logic [PIX_W-1:0] rgba_in;
	modport source (output valid, output pos_x, output pos_y, output rgba_in, input ready);
	modport sink (input valid, input pos_x, input pos_y, input rgba_in, output ready);
endinterface

interface rpfw_write_if;
	import rpfw_pkg::*;
	logic                valid;
	logic                ready;
	logic [ADDR_W-1:0]   byte_offset;
	logic [PIX_W-1:0]    write_data;
	logic [SBYTES_W-1:0] write_bytes;
	modport source (output valid, output byte_offset, output write_data, output write_bytes,
		input ready);
	modport sink (input valid, input byte_offset, input write_data, input write_bytes,
		output ready);
endinterface

interface rpfw_cfg_if;
	import rpfw_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface

// File: rtl/rpfw_cfg_regs.sv
// Configuration register file written through the config channel
module rpfw_cfg_regs (
	input  logic            clk,
	input  logic            arst_n,
	rpfw_cfg_if.sink        cfg,
	output rpfw_pkg::cfg_t  regs
);
	import rpfw_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= CFG_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.addr)
				REG_ROTATION:     regs_q.rotation     <= rot_t'(cfg.data[1:0]);
				REG_PIXEL_BITS:   regs_q.pixel_bits   <= cfg.data[PBITS_W-1:0];
				REG_STORE_BYTES:  regs_q.store_bytes  <= cfg.data[SBYTES_W-1:0];
				REG_RED_FIRST:    regs_q.red_first    <= cfg.data[0];
				REG_PANEL_WIDTH:  regs_q.panel_width  <= cfg.data[DIM_W-1:0];
				REG_PANEL_HEIGHT: regs_q.panel_height <= cfg.data[DIM_W-1:0];
				REG_LINE_STRIDE:  regs_q.line_stride  <= cfg.data[STRIDE_W-1:0];
				REG_BUFFER_BYTES: regs_q.buffer_bytes <= cfg.data[BUF_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// File: rtl/rpfw_color_pack.sv
// Colour packing: RGB565, spread 6-6-6, 8-8-8 or pass-through; alpha fills the top byte, ORed with red on pass-through
module rpfw_color_pack (
	input  rpfw_pkg::cfg_t            regs,
	input  logic [rpfw_pkg::PIX_W-1:0] rgba,
	output logic [rpfw_pkg::PIX_W-1:0] packed_px
);
	import rpfw_pkg::*;

	logic [7:0] r, g, b, a, hi, lo;

	assign r  = rgba[31:24];
	assign g  = rgba[23:16];
	assign b  = rgba[15:8];
	assign a  = rgba[7:0];
	assign hi = regs.red_first ? r : b;
	assign lo = regs.red_first ? b : r;

	always_comb begin
		case (regs.pixel_bits)
			PB_RGB565:   packed_px = {a, 8'h00, hi[7:3], g[7:2], lo[7:3]};
			PB_RGB666:   packed_px = {a, g[3:2], hi[7:2], lo[5:2], g[7:4], 6'b0, lo[7:6]};
			PB_RGB888,
			PB_RGBA8888: packed_px = {a, hi, g, lo};
			default:     packed_px = {rgba[31:24] | a, rgba[23:0]};
		endcase
	end

endmodule

// File: rtl/rpfw_addr_calc.sv
// Rotation, byte offset and buffer bounds check for one pixel
module rpfw_addr_calc (
	input  rpfw_pkg::cfg_t              regs,
	input  logic [rpfw_pkg::POS_W-1:0]  pos_x,
	input  logic [rpfw_pkg::POS_W-1:0]  pos_y,
	output logic [rpfw_pkg::ADDR_W-1:0] offset,
	output logic                        keep
);
	import rpfw_pkg::*;

	logic signed [CRD_W-1:0]        x_s, y_s, w_s, h_s, col, row;
	logic signed [2*CRD_W-1:0]      row_prod;
	logic signed [CRD_W+SBYTES_W:0] col_prod;
	logic signed [OFF_W-1:0]        off, limit;
	logic                           sb_ok;

	assign x_s = {{(CRD_W-POS_W){1'b0}}, pos_x};
	assign y_s = {{(CRD_W-POS_W){1'b0}}, pos_y};
	assign w_s = {{(CRD_W-DIM_W){1'b0}}, regs.panel_width};
	assign h_s = {{(CRD_W-DIM_W){1'b0}}, regs.panel_height};

	always_comb begin
		case (regs.rotation)
			ROT_90: begin
				col = y_s;
				row = h_s - x_s - 15'sd1;
			end
			ROT_180: begin
				col = w_s - x_s - 15'sd1;
				row = h_s - y_s - 15'sd1;
			end
			ROT_270: begin
				col = w_s - y_s - 15'sd1;
				row = x_s;
			end
			default: begin
				col = x_s;
				row = y_s;
			end
		endcase
	end

	assign row_prod = row * $signed({{(CRD_W-STRIDE_W){1'b0}}, regs.line_stride});
	assign col_prod = col * $signed({1'b0, regs.store_bytes});

	assign off = {{(OFF_W-2*CRD_W){row_prod[2*CRD_W-1]}}, row_prod}
		+ {{(OFF_W-CRD_W-SBYTES_W-1){col_prod[CRD_W+SBYTES_W]}}, col_prod};
	assign limit = {{(OFF_W-BUF_W){1'b0}}, regs.buffer_bytes}
		- {{(OFF_W-3){1'b0}}, regs.pixel_bits[5:3]};

	assign sb_ok  = (regs.store_bytes == SB_MIN) || (regs.store_bytes == SB_MID)
		|| (regs.store_bytes == SB_MAX);
	assign keep   = sb_ok && !off[OFF_W-1] && (off[OFF_W-2:ADDR_W] == '0) && !(off > limit);
	assign offset = off[ADDR_W-1:0];

endmodule

// File: rtl/rotated_pixel_format_writer_top.sv
// An accepted pixel is held in the input register, then its write in the result register.
// Throughput: one pixel per cycle; ready drops only when both stages hold and output stalls.
// Dropped pixels (out of buffer, negative offset, bad store size) give no write.
// Reset clears both stage valids and loads the default configuration.
// Config writes are taken every cycle and apply to pixels still in the input stage.
`include "rotated_pixel_format_writer_top_defines.svh"

module rotated_pixel_format_writer_top (
	input  logic        clk,
	input  logic        arst_n,
	rpfw_pixel_if.sink  pix,
	rpfw_write_if.source wr,
	rpfw_cfg_if.sink    cfg
);
	import rpfw_pkg::*;

	cfg_t                regs;
	logic                valid_s1, valid_s2;
	logic                adv_s1, adv_s2;
	logic [POS_W-1:0]    pos_x_s1, pos_y_s1;
	logic [PIX_W-1:0]    rgba_s1;
	logic [ADDR_W-1:0]   offset_c, offset_s2;
	logic [PIX_W-1:0]    data_c, data_s2;
	logic [SBYTES_W-1:0] bytes_s2;
	logic                keep_c;

	rpfw_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	rpfw_addr_calc u_addr (
		.regs   (regs),
		.pos_x  (pos_x_s1),
		.pos_y  (pos_y_s1),
		.offset (offset_c),
		.keep   (keep_c)
	);

	rpfw_color_pack u_pack (
		.regs      (regs),
		.rgba      (rgba_s1),
		.packed_px (data_c)
	);

	assign adv_s2    = !valid_s2 || wr.ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign pix.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= pix.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1 && keep_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && pix.valid) begin
			pos_x_s1 <= pix.pos_x;
			pos_y_s1 <= pix.pos_y;
			rgba_s1  <= pix.rgba_in;
		end
		if (adv_s2 && valid_s1) begin
			offset_s2 <= offset_c;
			data_s2   <= data_c;
			bytes_s2  <= regs.store_bytes;
		end
	end

	assign wr.valid       = valid_s2;
	assign wr.byte_offset = offset_s2;
	assign wr.write_data  = data_s2;
	assign wr.write_bytes = bytes_s2;

	`RPFW_ASSERT_SAME(a_stall_only_when_full, clk, arst_n, !pix.ready, valid_s1 && valid_s2 && !wr.ready)
	`RPFW_ASSERT_SAME(a_write_size_legal, clk, arst_n, valid_s2, (bytes_s2 == SB_MIN) || (bytes_s2 == SB_MID) || (bytes_s2 == SB_MAX))
	`RPFW_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, pix.valid && pix.ready, valid_s1)

endmodule

// File: bench/rotated_pixel_format_writer_top_test.sv
// Self-checking bench for the rotated pixel format writer: random and directed pixels
`timescale 1ns / 1ps

module rotated_pixel_format_writer_top_test;
	import rpfw_pkg::*;

	typedef struct {
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic [PIX_W-1:0] rgba;
	} pixel_t;

	typedef struct {
		logic [ADDR_W-1:0]   byte_offset;
		logic [PIX_W-1:0]    write_data;
		logic [SBYTES_W-1:0] write_bytes;
	} fb_write_t;

	logic clk;
	logic arst_n;

	rpfw_pixel_if pix ();
	rpfw_write_if wr ();
	rpfw_cfg_if   cfg ();

	rotated_pixel_format_writer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix.sink),
		.wr     (wr.source),
		.cfg    (cfg.sink)
	);

	cfg_t      regs_now;
	pixel_t    pixels_pending[$];
	fb_write_t fb_writes_due[$];
	pixel_t    px_on_bus;
	bit        idle_on;
	int        gap_left;
	int        stall_left;
	int        hold_left;
	int        hold_asks;
	int        holds_done;
	int        pixels_taken;
	int        writes_due_total;
	int        writes_seen;
	int        error_count;
	int        setups_done;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Expected framebuffer write for one pixel under a given register setup
	function automatic bit fb_write_for(input pixel_t p, input cfg_t c, output fb_write_t w);
		longint xs, ys, pw, ph, st, sb, col, row, off, lim;
		logic [31:0] r, g, b, a, hi, lo, px;
		xs = p.pos_x;
		ys = p.pos_y;
		pw = c.panel_width;
		ph = c.panel_height;
		st = c.line_stride;
		sb = c.store_bytes;
		w = '{default: '0};
		if (c.store_bytes < SB_MIN || c.store_bytes > SB_MAX)
			return 1'b0;
		case (c.rotation)
			ROT_90: begin
				col = ys;
				row = ph - xs - 1;
			end
			ROT_180: begin
				col = pw - xs - 1;
				row = ph - ys - 1;
			end
			ROT_270: begin
				col = pw - ys - 1;
				row = xs;
			end
			default: begin
				col = xs;
				row = ys;
			end
		endcase
		off = row * st + col * sb;
		lim = longint'(c.buffer_bytes) - longint'(c.pixel_bits >> 3);
		if (off < 0 || off > lim || off >= (longint'(1) << ADDR_W))
			return 1'b0;
		r = (p.rgba >> 24) & 32'hFF;
		g = (p.rgba >> 16) & 32'hFF;
		b = (p.rgba >> 8) & 32'hFF;
		a = p.rgba & 32'hFF;
		hi = c.red_first ? r : b;
		lo = c.red_first ? b : r;
		case (c.pixel_bits)
			PB_RGB565: px = ((hi >> 3) << 11) | ((g >> 2) << 5) | (lo >> 3);
			PB_RGB666: px = ((((hi >> 2) | ((g & 32'h0C) << 4)) & 32'hFF) << 16)
				| (((((g & 32'hF0) >> 4) | ((lo & 32'h3C) << 2)) & 32'hFF) << 8)
				| ((lo & 32'hC0) >> 6);
			PB_RGB888, PB_RGBA8888: px = (hi << 16) | (g << 8) | lo;
			default: px = p.rgba;
		endcase
		w.byte_offset = off[ADDR_W-1:0];
		w.write_data  = px | (a << 24);
		w.write_bytes = c.store_bytes;
		return 1'b1;
	endfunction

	// pixel source
	always @(posedge clk or negedge arst_n) begin
		fb_write_t w;
		if (!arst_n) begin
			pix.valid   <= 1'b0;
			pix.pos_x   <= '0;
			pix.pos_y   <= '0;
			pix.rgba_in <= '0;
			gap_left = 0;
		end else begin
			if (pix.valid && pix.ready) begin
				pixels_taken++;
				if (fb_write_for(px_on_bus, regs_now, w)) begin
					fb_writes_due.push_back(w);
					writes_due_total++;
				end
			end
			if (pix.valid && !pix.ready) begin
				// hold the offered transaction
			end else if (gap_left > 0) begin
				gap_left--;
				pix.valid <= 1'b0;
			end else if (pixels_pending.size() > 0) begin
				px_on_bus = pixels_pending.pop_front();
				pix.valid   <= 1'b1;
				pix.pos_x   <= px_on_bus.pos_x;
				pix.pos_y   <= px_on_bus.pos_y;
				pix.rgba_in <= px_on_bus.rgba;
				if (idle_on && $urandom_range(0, 7) == 0)
					gap_left = $urandom_range(1, 19);
			end else begin
				pix.valid <= 1'b0;
			end
		end
	end

	// write sink and checker
	always @(posedge clk or negedge arst_n) begin
		fb_write_t w;
		if (!arst_n) begin
			wr.ready <= 1'b0;
			stall_left = 0;
			hold_left = 0;
			holds_done = 0;
		end else begin
			if (wr.valid && wr.ready) begin
				writes_seen++;
				if (fb_writes_due.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("tb: unexpected write offset=%h data=%h bytes=%0d",
							wr.byte_offset, wr.write_data, wr.write_bytes);
				end else begin
					w = fb_writes_due.pop_front();
					if (w.byte_offset !== wr.byte_offset || w.write_data !== wr.write_data
							|| w.write_bytes !== wr.write_bytes) begin
						error_count++;
						if (error_count <= 10)
							$display("tb: write mismatch exp %h/%h/%0d got %h/%h/%0d",
								w.byte_offset, w.write_data, w.write_bytes,
								wr.byte_offset, wr.write_data, wr.write_bytes);
					end
				end
			end
			if (hold_asks != holds_done) begin
				holds_done = hold_asks;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				wr.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				wr.ready <= 1'b0;
			end else begin
				wr.ready <= 1'b1;
				if (idle_on && $urandom_range(0, 7) == 0)
					stall_left = $urandom_range(1, 19);
			end
		end
	end

	function automatic cfg_t make_setup(input rot_t rot, input int pb, input int sb,
			input bit rf, input int w, input int h, input int st, input int bb);
		cfg_t c;
		c.rotation     = rot;
		c.pixel_bits   = PBITS_W'(pb);
		c.store_bytes  = SBYTES_W'(sb);
		c.red_first    = rf;
		c.panel_width  = DIM_W'(w);
		c.panel_height = DIM_W'(h);
		c.line_stride  = STRIDE_W'(st);
		c.buffer_bytes = BUF_W'(bb);
		return c;
	endfunction

	function automatic cfg_t random_setup();
		cfg_t c;
		int pb, sb, w, h, st, bb;
		if ($urandom_range(0, 9) < 7) begin
			case ($urandom_range(0, 3))
				0: begin pb = PB_RGB565; sb = SB_MIN; end
				1: begin pb = PB_RGB666; sb = SB_MID; end
				2: begin pb = PB_RGB888; sb = SB_MID; end
				default: begin pb = PB_RGBA8888; sb = SB_MAX; end
			endcase
			if ($urandom_range(0, 7) == 0) begin
				w = $urandom_range(1, 4096);
				h = $urandom_range(1, 4096);
			end else begin
				w = $urandom_range(1, 64);
				h = $urandom_range(1, 64);
			end
			st = w * sb + sb * $urandom_range(0, 3);
			if (st > 16383)
				st = 16383;
			if ($urandom_range(0, 5) == 0)
				bb = 33554431;
			else
				bb = st * h + $urandom_range(0, 8) - 4;
			if (bb < 0)
				bb = 0;
			if (bb > 33554431)
				bb = 33554431;
			c = make_setup(rot_t'($urandom_range(0, 3)), pb, sb, $urandom_range(0, 1),
				w, h, st, bb);
		end else begin
			c = make_setup(rot_t'($urandom_range(0, 3)), $urandom_range(0, 63),
				$urandom_range(0, 7), $urandom_range(0, 1), $urandom_range(0, 8191),
				$urandom_range(0, 8191), $urandom_range(0, 16383),
				$urandom_range(0, 33554431));
		end
		return c;
	endfunction

	// mostly pixels on the logical panel, some anywhere in the field range
	function automatic pixel_t random_pixel(input cfg_t c);
		pixel_t p;
		int lw, lh;
		if (c.rotation == ROT_90 || c.rotation == ROT_270) begin
			lw = c.panel_height;
			lh = c.panel_width;
		end else begin
			lw = c.panel_width;
			lh = c.panel_height;
		end
		if (lw > 4096)
			lw = 4096;
		if (lh > 4096)
			lh = 4096;
		p.rgba = $urandom;
		if ($urandom_range(0, 9) < 8 && lw > 0 && lh > 0) begin
			p.pos_x = POS_W'($urandom_range(0, lw - 1));
			p.pos_y = POS_W'($urandom_range(0, lh - 1));
		end else begin
			p.pos_x = POS_W'($urandom);
			p.pos_y = POS_W'($urandom);
		end
		return p;
	endfunction

	task automatic send_pixel(input int x, input int y, input logic [31:0] rgba);
		pixel_t p;
		p.pos_x = POS_W'(x);
		p.pos_y = POS_W'(y);
		p.rgba  = rgba;
		pixels_pending.push_back(p);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pixels_pending.size() != 0 || pix.valid || fb_writes_due.size() != 0);
		// dropped pixels may still sit in the pipe
		repeat (6) @(posedge clk);
	endtask

	task automatic program_regs(input cfg_t c);
		logic [CFG_ADDR_W-1:0] idx[8];
		logic [CFG_DATA_W-1:0] val[8];
		idx = '{REG_ROTATION, REG_PIXEL_BITS, REG_STORE_BYTES, REG_RED_FIRST,
			REG_PANEL_WIDTH, REG_PANEL_HEIGHT, REG_LINE_STRIDE, REG_BUFFER_BYTES};
		val = '{CFG_DATA_W'(c.rotation), CFG_DATA_W'(c.pixel_bits), CFG_DATA_W'(c.store_bytes),
			CFG_DATA_W'(c.red_first), CFG_DATA_W'(c.panel_width), CFG_DATA_W'(c.panel_height),
			CFG_DATA_W'(c.line_stride), CFG_DATA_W'(c.buffer_bytes)};
		@(posedge clk);
		for (int i = 0; i < 8; i++) begin
			cfg.valid <= 1'b1;
			cfg.addr  <= idx[i];
			cfg.data  <= val[i];
			do @(posedge clk);
			while (!cfg.ready);
		end
		cfg.valid <= 1'b0;
		regs_now = c;
		setups_done++;
		repeat (2) @(posedge clk);
	endtask

	task automatic new_setup(input cfg_t c);
		wait_drained();
		program_regs(c);
	endtask

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		cfg_t c;
		int n;
		int missing;
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.addr = '0;
		cfg.data = '0;
		regs_now = CFG_RESET;
		idle_on = 1'b1;
		hold_asks = 0;
		setups_done = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset setup: corners, bottom edge beyond buffer, far corner
		send_pixel(0, 0, 32'h0000_0000);
		send_pixel(639, 479, 32'hFFFF_FFFF);
		send_pixel(0, 480, 32'h1234_5678);
		send_pixel(4095, 4095, 32'hA5A5_A5A5);
		send_pixel(1, 1, 32'h8040_2010);

		// ninety, 565 blue first; x past height gives a negative row
		new_setup(make_setup(ROT_90, PB_RGB565, SB_MIN, 1'b0, 320, 240, 640, 153600));
		send_pixel(0, 0, 32'hFFFF_FFFF);
		send_pixel(239, 319, 32'hF8FC_F855);
		send_pixel(240, 0, 32'h1122_3344);
		send_pixel(5, 7, $urandom);

		// one-eighty, 666; column or row below zero
		new_setup(make_setup(ROT_180, PB_RGB666, SB_MID, 1'b1, 100, 50, 300, 15000));
		send_pixel(0, 0, 32'hFFFF_FFFF);
		send_pixel(99, 49, 32'h3CC3_F00F);
		send_pixel(100, 0, 32'hC0FC_3C01);
		send_pixel(0, 50, 32'h5A5A_5A5A);

		// two-seventy, 888 on a 4096 by 4096 panel
		new_setup(make_setup(ROT_270, PB_RGB888, SB_MID, 1'b0, 4096, 4096, 12288, 16777216));
		send_pixel(0, 0, 32'h0102_0304);
		send_pixel(4095, 4095, 32'hFEDC_BA98);
		send_pixel(1365, 0, 32'h7777_7777);

		// offset right at and past the 24-bit address range
		new_setup(make_setup(ROT_0, PB_RGBA8888, SB_MAX, 1'b1, 4096, 4096, 16383, 33554431));
		send_pixel(255, 1024, 32'hDEAD_BEEF);
		send_pixel(256, 1024, 32'hCAFE_F00D);

		// other pixel depth passes colour through; last byte beyond the limit
		new_setup(make_setup(ROT_0, 63, SB_MAX, 1'b0, 8191, 8191, 0, 100));
		send_pixel(0, 5, 32'h0F1E_2D3C);
		send_pixel(23, 0, 32'h8000_00FF);
		send_pixel(24, 0, 32'h1234_5678);

		// unknown store sizes give no write
		new_setup(make_setup(ROT_0, 0, 0, 1'b1, 640, 480, 2560, 1228800));
		send_pixel(1, 1, 32'h5555_5555);
		new_setup(make_setup(ROT_0, 32, 7, 1'b1, 640, 480, 2560, 1228800));
		send_pixel(2, 2, 32'hAAAA_AAAA);

		for (int ph = 0; ph < 14; ph++) begin
			c = random_setup();
			if (ph >= 12)
				idle_on = 1'b0;
			new_setup(c);
			n = $urandom_range(60, 100);
			if (ph == 3) begin
				// long output stall while pixels keep coming
				c = make_setup(rot_t'($urandom_range(0, 3)), PB_RGB565, SB_MIN, 1'b1,
					32, 32, 64, 2048);
				new_setup(c);
				hold_asks++;
			end
			for (int i = 0; i < n; i++) begin
				if (ph == 5 && i == n / 2)
					wait_drained();
				pixels_pending.push_back(random_pixel(c));
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		missing = fb_writes_due.size();
		if (missing != 0)
			$display("tb: %0d expected writes never appeared", missing);
		$display("tb: covered %0d pixels over %0d register setups, %0d writes checked",
			pixels_taken, setups_done, writes_seen);
		$display("tb: %0d pixels dropped, %0d errors", pixels_taken - writes_due_total,
			error_count + missing);
		if (error_count == 0 && missing == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
